@@ rtl/core/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted set insert package
// Shared widths, defaults and the control bundle driven into every table cell.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int VALUE_W          = 64;
    localparam int OUT_W            = 11;
    localparam int CAPACITY_DEFAULT = 1024;

    typedef struct packed {
        logic cmp_en;    // compare the broadcast key against the stored entry
        logic shift_en;  // insert the key and move larger entries up one cell
    } ssi_ctrl_t;

endpackage

@@ rtl/core/sorted_set_insert_if_absent.sv @@
// ----------------------------------------------------------------------------
// Sorted set insert-if-absent
// Ascending table of distinct 64-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A value is transferred in at a rising edge where start is high and busy
//   is low. Every value yields exactly one result, shown for one cycle with
//   done high: found, position (lower-bound index), table_full and
//   entry_count. The receiver cannot stall the block.
//   Each value passes through a compare state, in which every cell compares
//   its entry against the key, and an update state, in which the cells at
//   and above the insert point take their neighbor's entry (or the key).
//   busy is high only in the compare state, so a new value may be started
//   during the update state. The output registers load at the edge that
//   ends the update state and hold the result until the next update.
//   Reset clears the entry count; the table contents stay undefined and are
//   never read above the count. Position and entry_count are reported modulo
//   2048 when CAPACITY exceeds 2047.
// ----------------------------------------------------------------------------
module sorted_set_insert_if_absent
    import ssi_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    output logic               done,
    output logic               found,
    output logic [OUT_W-1:0]   position,
    output logic               table_full,
    output logic [OUT_W-1:0]   entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [VALUE_W-1:0] key_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    logic               found_reg;
    logic [OUT_W-1:0]   position_reg;
    logic               table_full_reg;
    logic [OUT_W-1:0]   entry_count_reg;

    logic [VALUE_W-1:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] boundary;
    logic               take;
    logic               hit;
    logic               full;
    logic               ins;
    logic [CNT_W-1:0]   pos_enc;
    logic [CNT_W-1:0]   pos;
    ssi_ctrl_t          ctrl;

    assign take = start && (state_reg != S_CMP);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = take ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_UPD;
            S_UPD:   state_next = take ? S_CMP : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign hit  = |cell_eq;
    assign full = (count_reg == CNT_W'(CAPACITY));
    assign ins  = (state_reg == S_UPD) && !hit && !full;

    assign ctrl.cmp_en   = (state_reg == S_CMP);
    assign ctrl.shift_en = ins;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [VALUE_W-1:0] prev_entry;
            logic               prev_lt;
            if (i == 0)
            begin : g_first
                assign prev_entry = key_reg;
                assign prev_lt    = 1'b1;
            end
            else
            begin : g_rest
                assign prev_entry = cell_entry[i-1];
                assign prev_lt    = cell_lt[i-1];
            end

            assign boundary[i] = prev_lt && !cell_lt[i];

            ssi_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .occupied   (CNT_W'(i) < count_reg),
                .key        (key_reg),
                .prev_entry (prev_entry),
                .prev_lt    (prev_lt),
                .entry      (cell_entry[i]),
                .lt         (cell_lt[i]),
                .eq         (cell_eq[i])
            );
        end
    endgenerate

    // The less-than flags form a thermometer, so at most one cell sits on the edge.
    always_comb
    begin
        pos_enc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (boundary[i])
            begin
                pos_enc = pos_enc | CNT_W'(i);
            end
        end
    end

    assign pos        = cell_lt[CAPACITY-1] ? CNT_W'(CAPACITY) : pos_enc;
    assign count_next = ins ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == S_UPD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg <= value;
        end
        if (state_reg == S_UPD)
        begin
            found_reg       <= hit;
            position_reg    <= OUT_W'(pos);
            table_full_reg  <= !hit && full;
            entry_count_reg <= OUT_W'(count_next);
        end
    end

    assign busy        = (state_reg == S_CMP);
    assign done        = done_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign table_full  = table_full_reg;
    assign entry_count = entry_count_reg;

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_UPD))
        else $error("result strobe without a preceding update cycle");

    a_found_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(found && table_full))
        else $error("found and table_full reported together");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_single_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> $onehot0(boundary))
        else $error("more than one insert point in the table");

endmodule

@@ rtl/core/ssi_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted set table cell
// Holds one table entry, compares it against the broadcast key and takes
// either the key or its lower neighbor's entry when an insert opens a slot.
// ----------------------------------------------------------------------------
module ssi_cell
    import ssi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ssi_ctrl_t          ctrl,
    input  logic               occupied,
    input  logic [VALUE_W-1:0] key,
    input  logic [VALUE_W-1:0] prev_entry,
    input  logic               prev_lt,
    output logic [VALUE_W-1:0] entry,
    output logic               lt,
    output logic               eq
);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic               lt_reg;
    logic               lt_next;
    logic               eq_reg;
    logic               eq_next;

    always_comb
    begin
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        entry_next = entry_reg;
        if (ctrl.cmp_en)
        begin
            lt_next = occupied && (entry_reg < key);
            eq_next = occupied && (entry_reg == key);
        end
        // Cells at or above the insert point move; the cell right at it takes the key.
        if (ctrl.shift_en && !lt_reg)
        begin
            entry_next = prev_lt ? key : prev_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

@@ tb/tb_sorted_set_insert_if_absent.sv @@
// ----------------------------------------------------------------------------
// Sorted set insert-if-absent testbench
// Directed values and then random lookups are sent to the block. The random
// lookups fill the table, run on against the full table, and mix repeats,
// near misses and fresh values. Results are checked against typed-in
// expectations where given, else an in-bench model of the ascending table.
// ----------------------------------------------------------------------------
module tb_sorted_set_insert_if_absent;
    timeunit 1ns;
    timeprecision 1ps;

    import ssi_pkg::*;

    localparam int CAPACITY       = CAPACITY_DEFAULT;
    localparam int DIRECTED_N     = 20;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int MAX_RANDOM     = 4000;
    localparam int MIN_FULL_DROPS = 40;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] position;
        logic             table_full;
        logic [OUT_W-1:0] entry_count;
    } lookup_result_t;

    typedef struct packed {
        logic [VALUE_W-1:0] key;
        logic               fixed;  // expectation typed in below
        lookup_result_t     want;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [VALUE_W-1:0] value = '0;
    logic               busy;
    logic               done;
    logic               found;
    logic [OUT_W-1:0]   position;
    logic               table_full;
    logic [OUT_W-1:0]   entry_count;

    // Model of the table contents; only entries below set_size are valid.
    logic [VALUE_W-1:0] set_entries [CAPACITY];
    int unsigned        set_size = 0;

    lookup_result_t     pending_results[$];
    directed_row_t      directed_rows [DIRECTED_N];

    int unsigned        mismatches = 0;
    int unsigned        inserts = 0;
    int unsigned        repeats = 0;
    int unsigned        full_drops = 0;
    int unsigned        burst_left = 0;

    sorted_set_insert_if_absent #(
        .CAPACITY    (CAPACITY)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .done        (done),
        .found       (found),
        .position    (position),
        .table_full  (table_full),
        .entry_count (entry_count)
    );

    always #10 clk = ~clk;

    // Lower-bound search, then insert with shift when absent and not full.
    function automatic lookup_result_t predict_insert(input logic [VALUE_W-1:0] key);
        lookup_result_t res;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        lo = 0;
        hi = set_size;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (set_entries[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        res.found      = (lo < set_size) && (set_entries[lo] == key);
        res.table_full = 1'b0;
        if (res.found)
        begin
            repeats++;
        end
        else if (set_size >= CAPACITY)
        begin
            res.table_full = 1'b1;
            full_drops++;
        end
        else
        begin
            for (int unsigned i = set_size; i > lo; i--)
                set_entries[i] = set_entries[i - 1];
            set_entries[lo] = key;
            set_size++;
            inserts++;
        end
        res.position    = OUT_W'(lo);
        res.entry_count = OUT_W'(set_size);
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3)
        begin
            burst_left = $urandom_range(40, 10);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(30, 11);
    endfunction

    // Repeats and near misses of stored values grow more common once the
    // table is full, so both full-table cases are hit often.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] pick;
        int unsigned        r;
        int unsigned        hit_pct;
        int unsigned        near_pct;
        hit_pct  = (set_size == CAPACITY) ? 40 : 10;
        near_pct = (set_size == CAPACITY) ? 20 : 10;
        r = $urandom_range(99);
        if (set_size > 0 && r < hit_pct)
            return set_entries[$urandom_range(set_size - 1, 0)];
        if (set_size > 0 && r < hit_pct + near_pct)
        begin
            pick = set_entries[$urandom_range(set_size - 1, 0)];
            return $urandom_range(1) ? pick + 1'b1 : pick - 1'b1;
        end
        case ($urandom_range(9)) inside
            [0:1]:
                pick = VALUE_W'($urandom_range(4095));
            2:
                pick = {VALUE_W{1'b1}} - VALUE_W'($urandom_range(4095));
            3:
            begin
                pick = '0;
                pick[$urandom_range(VALUE_W - 1)] = 1'b1;
            end
            4:
            begin
                pick = '1;
                pick[$urandom_range(VALUE_W - 1)] = 1'b0;
            end
            default:
                pick = {$urandom, $urandom};
        endcase
        return pick;
    endfunction

    // Called just after a falling edge; returns just after a falling edge.
    task automatic drive_value(input logic [VALUE_W-1:0] key, input logic fixed,
                               input lookup_result_t fixed_want);
        lookup_result_t predicted;
        int unsigned    idle;
        start <= 1'b1;
        value <= key;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_insert(key);
        pending_results.push_back(fixed ? fixed_want : predicted);
        @(negedge clk);
        idle = pick_gap();
        if (idle > 0)
        begin
            start <= 1'b0;
            value <= {$urandom, $urandom};
            repeat (idle) @(negedge clk);
        end
    endtask

    task automatic report_mismatch(input string what, input lookup_result_t got,
                                   input lookup_result_t want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%t: %s: got found=%b position=%0d table_full=%b entry_count=%0d,",
                     $realtime, what, got.found, got.position, got.table_full,
                     got.entry_count);
            $display("    expected found=%b position=%0d table_full=%b entry_count=%0d",
                     want.found, want.position, want.table_full, want.entry_count);
        end
    endtask

    always @(posedge clk)
    begin
        lookup_result_t got;
        lookup_result_t want;
        if (rst_n && done === 1'b1)
        begin
            got = '{found, position, table_full, entry_count};
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no transfer pending", got, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_mismatch("result mismatch", got, want);
            end
        end
    end

    initial
    begin
        int unsigned random_items;
        directed_rows = '{
            '{64'h0000_0000_0000_0000, 1'b1, '{1'b0, 11'd0, 1'b0, 11'd1}},
            '{64'h0000_0000_0000_0000, 1'b1, '{1'b1, 11'd0, 1'b0, 11'd1}},
            '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 11'd1, 1'b0, 11'd2}},
            '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 11'd1, 1'b0, 11'd2}},
            '{64'h8000_0000_0000_0000, 1'b1, '{1'b0, 11'd1, 1'b0, 11'd3}},
            '{64'h0000_0000_0000_0001, 1'b1, '{1'b0, 11'd1, 1'b0, 11'd4}},
            '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, '{1'b0, 11'd3, 1'b0, 11'd5}},
            '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 11'd2, 1'b0, 11'd6}},
            '{64'h0000_0000_0000_0001, 1'b1, '{1'b1, 11'd1, 1'b0, 11'd6}},
            '{64'h8000_0000_0000_0000, 1'b1, '{1'b1, 11'd3, 1'b0, 11'd6}},
            '{64'h5555_5555_5555_5555, 1'b0, '0},
            '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
            '{64'h0000_0000_FFFF_FFFF, 1'b0, '0},
            '{64'hFFFF_FFFF_0000_0000, 1'b0, '0},
            '{64'h0123_4567_89AB_CDEF, 1'b0, '0},
            '{64'hFEDC_BA98_7654_3210, 1'b0, '0},
            '{64'h0000_0000_0000_0002, 1'b0, '0},
            '{64'h0000_0000_0000_0000, 1'b0, '0},
            '{64'hFFFF_FFFF_FFFF_FFFD, 1'b0, '0},
            '{64'h5555_5555_5555_5555, 1'b0, '0}
        };
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[row])
            drive_value(directed_rows[row].key, directed_rows[row].fixed,
                        directed_rows[row].want);

        // Keep going past the nominal count, up to MAX_RANDOM values, until the
        // full table has dropped a good number of values.
        random_items = 0;
        while (random_items < MAX_RANDOM &&
               (random_items < RANDOM_ITEMS || full_drops < MIN_FULL_DROPS))
        begin
            drive_value(pick_value(), 1'b0, '0);
            random_items++;
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d values (%0d directed): %0d inserted, %0d already present,",
                 DIRECTED_N + random_items, DIRECTED_N, inserts, repeats);
        $display("%0d dropped with the table full at %0d entries; %0d mismatches.",
                 full_drops, set_size, mismatches);
        if (mismatches == 0)
            $display("sorted_set_insert_if_absent regression: pass");
        else
            $display("sorted_set_insert_if_absent regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("sorted_set_insert_if_absent regression: fail");
        $finish;
    end

endmodule
